/* src/keyframe_servo_sequencer_top_assert.svh */
// Assertion macros for the keyframe servo sequencer checker.
`ifndef KEYFRAME_SERVO_SEQUENCER_TOP_ASSERT_SVH
`define KEYFRAME_SERVO_SEQUENCER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KSQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KSQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/ksq_pkg.sv */
// Shared types and constants of the keyframe servo sequencer.
package ksq_pkg;

   localparam int MOVE_DEPTH_DEF  = 32;
   localparam int JOINT_COUNT_DEF = 32;
   localparam int ADDR_W          = 6;
   localparam int ELAPSED_W       = 18;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_ANIM_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOP_ENABLE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOVE_COUNT  = 2'd2;

   typedef enum logic [2:0] {
      MODE_TICK      = 3'd0,
      MODE_RESTART   = 3'd1,
      MODE_START     = 3'd2,
      MODE_STOP      = 3'd3,
      MODE_LOAD_MOVE = 3'd4,
      MODE_LOAD_BIND = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EMIT,
      ST_STATUS
   } state_type;

   typedef struct packed {
      logic [15:0]       key_time;
      logic [4:0]        joint;
      logic signed [9:0] angle;
      logic [15:0]       duration;
   } move_entry_type;

   typedef struct packed {
      logic              wr;
      logic              rd;
      logic [ADDR_W-1:0] addr;
      move_entry_type    wdata;
   } move_port_type;

   typedef struct packed {
      logic              wr;
      logic              rd;
      logic [ADDR_W-1:0] addr;
      logic              bound;
      logic [4:0]        servo;
   } bind_port_type;

   typedef struct packed {
      logic       valid;
      logic [4:0] servo;
   } bind_entry_type;

endpackage

/* src/ksq_move_mem.sv */
// Move table: synchronous single-port memory with registered read data.
module ksq_move_mem #(
   parameter int MOVE_DEPTH = ksq_pkg::MOVE_DEPTH_DEF
) (
   input  logic                    clock,
   input  ksq_pkg::move_port_type  port,
   output ksq_pkg::move_entry_type rd_data
);
   import ksq_pkg::*;

   localparam int AW = (MOVE_DEPTH > 1) ? $clog2(MOVE_DEPTH) : 1;

   move_entry_type entries_ff [MOVE_DEPTH];
   move_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (port.wr) begin
         entries_ff[port.addr[AW-1:0]] <= port.wdata;
      end
      if (port.rd) begin
         rd_data_ff <= entries_ff[port.addr[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/ksq_bind_mem.sv */
// Binding table: servo memory with per-joint valid flags cleared at reset.
module ksq_bind_mem #(
   parameter int JOINT_COUNT = ksq_pkg::JOINT_COUNT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ksq_pkg::bind_port_type  port,
   output ksq_pkg::bind_entry_type rd_data
);
   import ksq_pkg::*;

   localparam int AW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

   logic [4:0]             servo_ff [JOINT_COUNT];
   logic [JOINT_COUNT-1:0] valid_ff;
   bind_entry_type         rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (port.wr) begin
         valid_ff[port.addr[AW-1:0]] <= port.bound;
      end
   end

   always_ff @(posedge clock) begin
      if (port.wr) begin
         servo_ff[port.addr[AW-1:0]] <= port.servo;
      end
      if (port.rd) begin
         rd_data_ff.valid <= valid_ff[port.addr[AW-1:0]];
         rd_data_ff.servo <= servo_ff[port.addr[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/ksq_ctrl.sv */
// Sequencer control: command decode, table walk, timing state and result beats.
module ksq_ctrl #(
   parameter int MOVE_DEPTH  = ksq_pkg::MOVE_DEPTH_DEF,
   parameter int JOINT_COUNT = ksq_pkg::JOINT_COUNT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [2:0]                           req_mode,
   input  logic [15:0]                          req_amount_ms,
   input  logic [4:0]                           req_slot_index,
   input  logic [15:0]                          req_key_time_ms,
   input  logic [4:0]                           req_joint_id,
   input  logic signed [9:0]                    req_target_angle,
   input  logic [15:0]                          req_move_duration_ms,
   input  logic [4:0]                           req_servo_id,
   input  logic                                 req_bound,
   input  logic                                 csr_we,
   input  logic [ksq_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ksq_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output ksq_pkg::move_port_type               move_port,
   input  ksq_pkg::move_entry_type              move_rdata,
   output ksq_pkg::bind_port_type               bind_port,
   input  ksq_pkg::bind_entry_type              bind_rdata,
   output logic                                 rsp_valid,
   output logic                                 rsp_kind,
   output logic [4:0]                           rsp_servo_out,
   output logic signed [9:0]                    rsp_angle_out,
   output logic [15:0]                          rsp_duration_out,
   output logic                                 rsp_was_active,
   output logic                                 rsp_last
);
   import ksq_pkg::*;

   localparam logic [ADDR_W-1:0] DEPTH_LIM  = ADDR_W'(MOVE_DEPTH);
   localparam logic [ADDR_W:0]   JOINT_LIM  = (ADDR_W + 1)'(JOINT_COUNT);

   state_type                   state_ff, state_in;
   logic signed [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [ADDR_W-1:0]           next_ff, next_in;
   logic                        running_ff, running_in;
   logic                        act_ff, act_in;
   logic [15:0]                 len_ff, len_in;
   logic                        loop_ff, loop_in;
   logic [5:0]                  count_ff, count_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_kind_ff, rsp_kind_in;
   logic [4:0]                  rsp_servo_ff, rsp_servo_in;
   logic signed [9:0]           rsp_angle_ff, rsp_angle_in;
   logic [15:0]                 rsp_duration_ff, rsp_duration_in;
   logic                        rsp_act_ff, rsp_act_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic [ADDR_W-1:0]           limit;
   logic [ADDR_W-1:0]           next_plus;
   logic signed [ELAPSED_W-1:0] amount_ext;
   logic signed [ELAPSED_W-1:0] key_ext;
   logic signed [ELAPSED_W-1:0] len_ext;
   logic                        joint_ok;

   assign limit      = (count_ff > DEPTH_LIM) ? DEPTH_LIM : count_ff;
   assign next_plus  = next_ff + ADDR_W'(1);
   assign amount_ext = $signed({2'b00, req_amount_ms});
   assign key_ext    = $signed({2'b00, move_rdata.key_time});
   assign len_ext    = $signed({2'b00, len_ff});
   assign joint_ok   = {2'b00, move_rdata.joint} < JOINT_LIM;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         elapsed_ff   <= '0;
         next_ff      <= '0;
         running_ff   <= 1'b0;
         act_ff       <= 1'b0;
         len_ff       <= '0;
         loop_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         elapsed_ff   <= elapsed_in;
         next_ff      <= next_in;
         running_ff   <= running_in;
         act_ff       <= act_in;
         len_ff       <= len_in;
         loop_ff      <= loop_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff     <= rsp_kind_in;
      rsp_servo_ff    <= rsp_servo_in;
      rsp_angle_ff    <= rsp_angle_in;
      rsp_duration_ff <= rsp_duration_in;
      rsp_act_ff      <= rsp_act_in;
      rsp_last_ff     <= rsp_last_in;
   end

   always_comb begin
      state_in        = state_ff;
      elapsed_in      = elapsed_ff;
      next_in         = next_ff;
      running_in      = running_ff;
      act_in          = act_ff;
      len_in          = len_ff;
      loop_in         = loop_ff;
      count_in        = count_ff;
      rsp_valid_in    = 1'b0;
      rsp_kind_in     = 1'b0;
      rsp_servo_in    = '0;
      rsp_angle_in    = '0;
      rsp_duration_in = '0;
      rsp_act_in      = 1'b0;
      rsp_last_in     = 1'b0;
      move_port       = '0;
      bind_port       = '0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_ANIM_LENGTH: len_in   = csr_wdata[15:0];
            CSR_LOOP_ENABLE: loop_in  = csr_wdata[0];
            CSR_MOVE_COUNT:  count_in = csr_wdata[5:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               act_in   = 1'b0;
               state_in = ST_STATUS;
               unique case (req_mode)
                  MODE_TICK: begin
                     if (running_ff) begin
                        act_in     = 1'b1;
                        elapsed_in = elapsed_ff + amount_ext;
                        if (next_ff < limit) begin
                           move_port.rd   = 1'b1;
                           move_port.addr = next_ff;
                           state_in       = ST_FETCH;
                        end
                     end
                  end
                  MODE_RESTART: begin
                     next_in    = '0;
                     elapsed_in = -amount_ext;
                     running_in = 1'b1;
                  end
                  MODE_START: running_in = 1'b1;
                  MODE_STOP:  running_in = 1'b0;
                  MODE_LOAD_MOVE: begin
                     if ({1'b0, req_slot_index} < DEPTH_LIM) begin
                        move_port.wr             = 1'b1;
                        move_port.addr           = {1'b0, req_slot_index};
                        move_port.wdata.key_time = req_key_time_ms;
                        move_port.wdata.joint    = req_joint_id;
                        move_port.wdata.angle    = req_target_angle;
                        move_port.wdata.duration = req_move_duration_ms;
                     end
                  end
                  MODE_LOAD_BIND: begin
                     if ({2'b00, req_slot_index} < JOINT_LIM) begin
                        bind_port.wr    = 1'b1;
                        bind_port.addr  = {1'b0, req_slot_index};
                        bind_port.bound = req_bound;
                        bind_port.servo = req_servo_id;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FETCH: begin
            if (elapsed_ff >= key_ext) begin
               bind_port.rd   = joint_ok;
               bind_port.addr = {1'b0, move_rdata.joint};
               state_in       = ST_EMIT;
            end else begin
               state_in = ST_STATUS;
            end
         end
         ST_EMIT: begin
            if (joint_ok && bind_rdata.valid) begin
               rsp_valid_in    = 1'b1;
               rsp_servo_in    = bind_rdata.servo;
               rsp_angle_in    = move_rdata.angle;
               rsp_duration_in = move_rdata.duration;
            end
            next_in = next_plus;
            if (next_plus < limit) begin
               move_port.rd   = 1'b1;
               move_port.addr = next_plus;
               state_in       = ST_FETCH;
            end else begin
               state_in = ST_STATUS;
            end
         end
         ST_STATUS: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = 1'b1;
            rsp_act_in   = act_ff;
            rsp_last_in  = 1'b1;
            if (act_ff && (elapsed_ff >= len_ext)) begin
               elapsed_in = '0;
               next_in    = '0;
               running_in = loop_ff;
            end
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_servo_out    = rsp_servo_ff;
   assign rsp_angle_out    = rsp_angle_ff;
   assign rsp_duration_out = rsp_duration_ff;
   assign rsp_was_active   = rsp_act_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

/* src/keyframe_servo_sequencer_top.sv */
// Keyframe servo sequencer: top level joining control and the two tables.
// A command's status beat follows acceptance through the status state and the beat register;
// a running tick first steps through the move entries it passes (move table read, then binding
// table read) and stops after reading the first entry within the move count whose time is ahead.
// The next command is taken in the cycle the status beat is shown; results cannot stall.
// Synchronous reset stops playback, zeroes time, pointer and registers, and unbinds all joints.
module keyframe_servo_sequencer_top #(
   parameter int MOVE_DEPTH  = ksq_pkg::MOVE_DEPTH_DEF,
   parameter int JOINT_COUNT = ksq_pkg::JOINT_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [2:0]                      req_mode,
   input  logic [15:0]                     req_amount_ms,
   input  logic [4:0]                      req_slot_index,
   input  logic [15:0]                     req_key_time_ms,
   input  logic [4:0]                      req_joint_id,
   input  logic signed [9:0]               req_target_angle,
   input  logic [15:0]                     req_move_duration_ms,
   input  logic [4:0]                      req_servo_id,
   input  logic                            req_bound,
   input  logic                            csr_we,
   input  logic [ksq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ksq_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                            rsp_valid,
   output logic                            rsp_kind,
   output logic [4:0]                      rsp_servo_out,
   output logic signed [9:0]               rsp_angle_out,
   output logic [15:0]                     rsp_duration_out,
   output logic                            rsp_was_active,
   output logic                            rsp_last
);
   import ksq_pkg::*;

   move_port_type  move_port;
   move_entry_type move_rdata;
   bind_port_type  bind_port;
   bind_entry_type bind_rdata;

   ksq_ctrl #(
      .MOVE_DEPTH  (MOVE_DEPTH),
      .JOINT_COUNT (JOINT_COUNT)
   ) u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_mode             (req_mode),
      .req_amount_ms        (req_amount_ms),
      .req_slot_index       (req_slot_index),
      .req_key_time_ms      (req_key_time_ms),
      .req_joint_id         (req_joint_id),
      .req_target_angle     (req_target_angle),
      .req_move_duration_ms (req_move_duration_ms),
      .req_servo_id         (req_servo_id),
      .req_bound            (req_bound),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .move_port            (move_port),
      .move_rdata           (move_rdata),
      .bind_port            (bind_port),
      .bind_rdata           (bind_rdata),
      .rsp_valid            (rsp_valid),
      .rsp_kind             (rsp_kind),
      .rsp_servo_out        (rsp_servo_out),
      .rsp_angle_out        (rsp_angle_out),
      .rsp_duration_out     (rsp_duration_out),
      .rsp_was_active       (rsp_was_active),
      .rsp_last             (rsp_last)
   );

   ksq_move_mem #(
      .MOVE_DEPTH (MOVE_DEPTH)
   ) u_move_mem (
      .clock   (clock),
      .port    (move_port),
      .rd_data (move_rdata)
   );

   ksq_bind_mem #(
      .JOINT_COUNT (JOINT_COUNT)
   ) u_bind_mem (
      .clock   (clock),
      .reset   (reset),
      .port    (bind_port),
      .rd_data (bind_rdata)
   );

endmodule

/* src/ksq_checker.sv */
// Port-level checker for the keyframe servo sequencer and its bind statement.
`include "keyframe_servo_sequencer_top_assert.svh"

module ksq_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_kind,
   input logic rsp_last
);

   `KSQ_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted command did not raise busy")
   `KSQ_ASSERT_NEXT(a_accept_quiet, clock, reset, start && !busy, !rsp_valid, "beat shown straight after acceptance")
   `KSQ_ASSERT_NOW(a_move_busy, clock, reset, rsp_valid && !rsp_kind, busy, "move beat shown while idle")
   `KSQ_ASSERT_NOW(a_done_status, clock, reset, $fell(busy), rsp_valid && rsp_kind && rsp_last, "command finished without a status beat")

endmodule

bind keyframe_servo_sequencer_top ksq_checker u_ksq_checker (.*);

/* verif/keyframe_servo_sequencer_top_tb.sv */
// Self-checking testbench for the keyframe servo sequencer with its own predictor.
`timescale 1ns / 100ps

module keyframe_servo_sequencer_top_tb;
   import ksq_pkg::*;

   localparam int MOVE_DEPTH  = MOVE_DEPTH_DEF;
   localparam int JOINT_COUNT = JOINT_COUNT_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_CMDS = 230;

   localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
   localparam logic [2:0] MODE_UNUSED_7 = 3'd7;
   localparam logic       KIND_MOVE     = 1'b0;
   localparam logic       KIND_STATUS   = 1'b1;

   typedef struct packed {
      logic [2:0]        mode;
      logic [15:0]       amount;
      logic [4:0]        slot;
      logic [15:0]       key_time;
      logic [4:0]        joint;
      logic signed [9:0] angle;
      logic [15:0]       duration;
      logic [4:0]        servo;
      logic              bound;
   } sequencer_cmd_type;

   typedef struct packed {
      logic              kind;
      logic [4:0]        servo;
      logic signed [9:0] angle;
      logic [15:0]       duration;
      logic              was_active;
      logic              last;
   } sequencer_beat_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [2:0]             req_mode = '0;
   logic [15:0]            req_amount_ms = '0;
   logic [4:0]             req_slot_index = '0;
   logic [15:0]            req_key_time_ms = '0;
   logic [4:0]             req_joint_id = '0;
   logic signed [9:0]      req_target_angle = '0;
   logic [15:0]            req_move_duration_ms = '0;
   logic [4:0]             req_servo_id = '0;
   logic                   req_bound = 1'b0;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   rsp_valid;
   logic                   rsp_kind;
   logic [4:0]             rsp_servo_out;
   logic signed [9:0]      rsp_angle_out;
   logic [15:0]            rsp_duration_out;
   logic                   rsp_was_active;
   logic                   rsp_last;

   keyframe_servo_sequencer_top #(
      .MOVE_DEPTH (MOVE_DEPTH),
      .JOINT_COUNT(JOINT_COUNT)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_mode            (req_mode),
      .req_amount_ms       (req_amount_ms),
      .req_slot_index      (req_slot_index),
      .req_key_time_ms     (req_key_time_ms),
      .req_joint_id        (req_joint_id),
      .req_target_angle    (req_target_angle),
      .req_move_duration_ms(req_move_duration_ms),
      .req_servo_id        (req_servo_id),
      .req_bound           (req_bound),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_kind            (rsp_kind),
      .rsp_servo_out       (rsp_servo_out),
      .rsp_angle_out       (rsp_angle_out),
      .rsp_duration_out    (rsp_duration_out),
      .rsp_was_active      (rsp_was_active),
      .rsp_last            (rsp_last)
   );

   always #4 clock = ~clock;

   sequencer_cmd_type  pending_cmds[$];
   sequencer_beat_type expected_beats[$];
   int                 queued_cmds = 0;
   int                 fail_count = 0;
   int                 cycle_count = 0;
   bit                 gaps_on = 1'b1;

   // Predictor state and register copies.
   int             seq_elapsed = 0;
   int             seq_next = 0;
   logic           seq_running = 1'b0;
   logic [15:0]    reg_length = '0;
   logic           reg_loop = 1'b0;
   logic [5:0]     reg_count = '0;
   move_entry_type move_mem[MOVE_DEPTH] = '{default: '0};
   bind_entry_type bind_mem[JOINT_COUNT] = '{default: '0};

   function automatic void predict_sequencer_beats(input sequencer_cmd_type c);
      int             lim;
      logic           active;
      move_entry_type ent;
      active = 1'b0;
      case (c.mode)
         MODE_TICK: begin
            if (seq_running) begin
               lim = (reg_count > MOVE_DEPTH) ? MOVE_DEPTH : int'(reg_count);
               active = 1'b1;
               seq_elapsed += int'(c.amount);
               while (seq_next < lim && seq_elapsed >= int'(move_mem[seq_next].key_time)) begin
                  ent = move_mem[seq_next];
                  if (ent.joint < JOINT_COUNT && bind_mem[ent.joint].valid) begin
                     expected_beats.push_back('{KIND_MOVE, bind_mem[ent.joint].servo,
                                                ent.angle, ent.duration, 1'b0, 1'b0});
                  end
                  seq_next++;
               end
               if (seq_elapsed >= int'(reg_length)) begin
                  seq_elapsed = 0;
                  seq_next = 0;
                  if (!reg_loop) begin
                     seq_running = 1'b0;
                  end
               end
            end
         end
         MODE_RESTART: begin
            seq_next = 0;
            seq_elapsed = -int'(c.amount);
            seq_running = 1'b1;
         end
         MODE_START: begin
            seq_running = 1'b1;
         end
         MODE_STOP: begin
            seq_running = 1'b0;
         end
         MODE_LOAD_MOVE: begin
            if (c.slot < MOVE_DEPTH) begin
               move_mem[c.slot] = '{c.key_time, c.joint, c.angle, c.duration};
            end
         end
         MODE_LOAD_BIND: begin
            if (c.slot < JOINT_COUNT) begin
               bind_mem[c.slot] = '{c.bound, c.servo};
            end
         end
         default: ;
      endcase
      expected_beats.push_back('{KIND_STATUS, 5'd0, 10'sd0, 16'd0, active, 1'b1});
   endfunction

   function automatic sequencer_cmd_type rand_cmd();
      sequencer_cmd_type c;
      c.mode = 3'($urandom_range(0, 7));
      c.amount = 16'($urandom());
      c.slot = 5'($urandom());
      c.key_time = 16'($urandom());
      c.joint = 5'($urandom());
      c.angle = 10'(int'($urandom_range(0, 720)) - 360);
      c.duration = 16'($urandom());
      c.servo = 5'($urandom());
      c.bound = 1'($urandom());
      return c;
   endfunction

   task automatic push_ctrl(input logic [2:0] mode, input logic [15:0] amount);
      sequencer_cmd_type c;
      c = rand_cmd();
      c.mode = mode;
      c.amount = amount;
      pending_cmds.push_back(c);
      queued_cmds++;
   endtask

   task automatic push_move(input logic [4:0] slot, input logic [15:0] key_time,
                            input logic [4:0] joint, input logic signed [9:0] angle,
                            input logic [15:0] duration);
      sequencer_cmd_type c;
      c = rand_cmd();
      c.mode = MODE_LOAD_MOVE;
      c.slot = slot;
      c.key_time = key_time;
      c.joint = joint;
      c.angle = angle;
      c.duration = duration;
      pending_cmds.push_back(c);
      queued_cmds++;
   endtask

   task automatic push_bind(input logic [4:0] joint, input logic [4:0] servo, input logic bnd);
      sequencer_cmd_type c;
      c = rand_cmd();
      c.mode = MODE_LOAD_BIND;
      c.slot = joint;
      c.servo = servo;
      c.bound = bnd;
      pending_cmds.push_back(c);
      queued_cmds++;
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_ANIM_LENGTH: reg_length = val;
         CSR_LOOP_ENABLE: reg_loop = val[0];
         CSR_MOVE_COUNT:  reg_count = val[5:0];
         default: ;
      endcase
   endtask

   task automatic wait_quiet();
      do begin
         @(negedge clock);
      end while (pending_cmds.size() != 0 || start || busy || expected_beats.size() != 0);
   endtask

   task automatic configure(input int len, input int loop_on, input int cnt);
      wait_quiet();
      repeat (4) @(posedge clock);
      csr_write(CSR_ANIM_LENGTH, 16'(len));
      csr_write(CSR_LOOP_ENABLE, 16'(loop_on));
      csr_write(CSR_MOVE_COUNT, 16'(cnt));
      @(negedge clock);
   endtask

   // Playback phase: frame-ordered schedule, bindings, a restart, start or neither, and ticks.
   task automatic run_random_phase(input bit fill_all);
      int          n, step, t, len, cnt, r, ticks;
      logic [15:0] keys[MOVE_DEPTH];
      logic [4:0]  joints[MOVE_DEPTH];
      n = fill_all ? MOVE_DEPTH :
          (($urandom_range(0, 5) == 0) ? $urandom_range(1, MOVE_DEPTH) : $urandom_range(1, 8));
      step = ($urandom_range(0, 3) == 0) ? 65535 / n : $urandom_range(1, 300);
      t = $urandom_range(0, step);
      for (int i = 0; i < n; i++) begin
         keys[i] = (t > 65535) ? 16'hFFFF : 16'(t);
         joints[i] = 5'($urandom_range(0, JOINT_COUNT - 1));
         t += $urandom_range(0, step);
      end
      r = $urandom_range(0, 7);
      if (r == 0) begin
         len = 0;
      end else if (r == 1) begin
         len = 65535;
      end else begin
         len = int'(keys[n-1]) + $urandom_range(0, 2 * step);
         if (len > 65535) begin
            len = 65535;
         end
      end
      r = $urandom_range(0, 9);
      cnt = (r < 7) ? n : (r == 7) ? $urandom_range(0, n) :
            (r == 8) ? $urandom_range(MOVE_DEPTH + 1, 63) : MOVE_DEPTH;
      configure(len, $urandom_range(0, 1), cnt);
      gaps_on = ($urandom_range(0, 3) != 0);

      for (int i = 0; i < n; i++) begin
         push_bind(joints[i], 5'($urandom()), $urandom_range(0, 3) != 0);
      end
      for (int i = 0; i < n; i++) begin
         push_move(5'(i), keys[i], joints[i], 10'(int'($urandom_range(0, 720)) - 360),
                   16'($urandom()));
      end
      r = $urandom_range(0, 9);
      if (r < 3) begin
         push_ctrl(MODE_RESTART, 16'd0);
      end else if (r < 7) begin
         push_ctrl(MODE_RESTART, 16'($urandom_range(0, 300)));
      end else if (r == 7) begin
         push_ctrl(MODE_RESTART, 16'($urandom()));
      end else if (r == 8) begin
         push_ctrl(MODE_START, 16'($urandom()));
      end
      ticks = n + $urandom_range(2, 8);
      for (int i = 0; i < ticks; i++) begin
         r = $urandom_range(0, 19);
         if (r < 2) begin
            push_ctrl(3'($urandom_range(0, 7)), 16'($urandom()));
         end else if (r == 2) begin
            push_ctrl(MODE_TICK, 16'($urandom()));
         end else begin
            push_ctrl(MODE_TICK, 16'($urandom_range(0, step + step / 2)));
         end
      end
   endtask

   // Sender: bursts of commands separated by random gaps.
   sequencer_cmd_type cur_cmd;
   int                gap_left = 0;
   int                burst_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_sequencer_beats(cur_cmd);
         end
         if (!start || !busy) begin
            if (gap_left == 0 && pending_cmds.size() > 0) begin
               cur_cmd = pending_cmds.pop_front();
               req_mode <= cur_cmd.mode;
               req_amount_ms <= cur_cmd.amount;
               req_slot_index <= cur_cmd.slot;
               req_key_time_ms <= cur_cmd.key_time;
               req_joint_id <= cur_cmd.joint;
               req_target_angle <= cur_cmd.angle;
               req_move_duration_ms <= cur_cmd.duration;
               req_servo_id <= cur_cmd.servo;
               req_bound <= cur_cmd.bound;
               start <= 1'b1;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 8);
                  gap_left = gaps_on ? $urandom_range(0, 6) : 0;
               end else begin
                  burst_left--;
               end
            end else begin
               if (gap_left > 0) begin
                  gap_left--;
               end
               start <= 1'b0;
            end
         end
      end
   end

   task automatic report_beat_error(input string what, input sequencer_beat_type want,
                                    input sequencer_beat_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s: expected kind=%0d servo=%0d angle=%0d dur=%0d act=%0d last=%0d",
                  what, want.kind, want.servo, want.angle, want.duration, want.was_active,
                  want.last);
         $display("   got kind=%0d servo=%0d angle=%0d dur=%0d act=%0d last=%0d",
                  got.kind, got.servo, got.angle, got.duration, got.was_active, got.last);
      end
   endtask

   // Receiver: every result beat is checked against the oldest expectation.
   sequencer_beat_type seen_beat;
   sequencer_beat_type want_beat;

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         seen_beat = '{rsp_kind, rsp_servo_out, rsp_angle_out, rsp_duration_out,
                       rsp_was_active, rsp_last};
         if (expected_beats.size() == 0) begin
            report_beat_error("unexpected beat", '0, seen_beat);
         end else begin
            want_beat = expected_beats.pop_front();
            if (seen_beat !== want_beat) begin
               report_beat_error("mismatch", want_beat, seen_beat);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int directed_cmds;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A stopped tick, unused modes, table loads and a zero-length rewind.
      push_ctrl(MODE_TICK, 16'd100);
      push_ctrl(MODE_UNUSED_6, 16'hFFFF);
      push_ctrl(MODE_UNUSED_7, 16'h0000);
      push_bind(5'd0, 5'd31, 1'b1);
      push_bind(5'd31, 5'd0, 1'b1);
      push_bind(5'd5, 5'd17, 1'b0);
      push_move(5'd0, 16'd0, 5'd0, -10'sd360, 16'hFFFF);
      push_move(5'd1, 16'd10, 5'd31, 10'sd360, 16'd0);
      push_move(5'd2, 16'd20, 5'd5, 10'sd1, 16'd1);
      push_move(5'd3, 16'd300, 5'd0, -10'sd1, 16'd500);
      push_move(5'd4, 16'd400, 5'd31, 10'sd255, 16'h8000);
      push_move(5'd5, 16'd500, 5'd7, -10'sd256, 16'h7FFF);
      push_move(5'd6, 16'd900, 5'd0, 10'sd0, 16'd42);
      push_move(5'd7, 16'hFFFF, 5'd31, 10'sd0, 16'd9);
      push_ctrl(MODE_START, 16'd0);
      push_ctrl(MODE_TICK, 16'd0);
      push_ctrl(MODE_STOP, 16'd0);

      // Looping playback with the largest delay and tick.
      configure(1000, 1, 8);
      push_ctrl(MODE_RESTART, 16'd0);
      push_ctrl(MODE_TICK, 16'd0);
      push_ctrl(MODE_TICK, 16'd25);
      push_ctrl(MODE_TICK, 16'd480);
      push_ctrl(MODE_TICK, 16'hFFFF);
      push_ctrl(MODE_RESTART, 16'hFFFF);
      push_ctrl(MODE_TICK, 16'hFFFF);
      push_ctrl(MODE_STOP, 16'd0);
      push_ctrl(MODE_START, 16'd0);

      // The move count is then lowered below the entry pointer.
      configure(65535, 1, 8);
      push_ctrl(MODE_TICK, 16'd450);
      configure(65535, 0, 2);
      push_ctrl(MODE_TICK, 16'hFFFF);
      directed_cmds = queued_cmds;

      run_random_phase(1'b1);
      while (queued_cmds < directed_cmds + RANDOM_CMDS) begin
         run_random_phase(1'b0);
      end

      wait_quiet();
      repeat (100) @(posedge clock);
      if (fail_count == 0 && expected_beats.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* keyframe_servo_sequencer_top.f */
+incdir+src
src/ksq_pkg.sv
src/ksq_move_mem.sv
src/ksq_bind_mem.sv
src/ksq_ctrl.sv
src/keyframe_servo_sequencer_top.sv
src/ksq_checker.sv
verif/keyframe_servo_sequencer_top_tb.sv
